@@ hw/rtl/gbs_pkg.sv @@
package gbs_pkg;

	localparam int LENGTH_WIDTH = 16;
	localparam int BYTES_WIDTH  = 40;
	localparam int STAMP_WIDTH  = 64;
	localparam int FSIZE_WIDTH  = 32;
	localparam int COUNT_WIDTH  = 32;
	localparam int TYPE_WIDTH   = 2;

	localparam int IN_DATA_BITS   = STAMP_WIDTH + FSIZE_WIDTH;
	localparam int IN_DATA_WIDTH  = ((IN_DATA_BITS + 7) / 8) * 8;
	localparam int IN_USER_WIDTH  = TYPE_WIDTH + 1;
	localparam int OUT_DATA_BITS  = 2 * COUNT_WIDTH + 2 * STAMP_WIDTH + 6 * LENGTH_WIDTH
		+ BYTES_WIDTH;
	localparam int OUT_DATA_WIDTH = ((OUT_DATA_BITS + 7) / 8) * 8;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [TYPE_WIDTH-1:0] {
		FT_INTRA   = 2'd0,
		FT_FORWARD = 2'd1,
		FT_BIDIR   = 2'd2,
		FT_OTHER   = 2'd3
	} frame_type_t;

	// How a frame relates to the open group
	typedef enum logic [1:0] {
		KIND_JOIN  = 2'd0,
		KIND_OPEN  = 2'd1,
		KIND_SPLIT = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic                    stream_end;
		frame_type_t             ftype;
		logic [STAMP_WIDTH-1:0]  stamp;
		logic [FSIZE_WIDTH-1:0]  fbytes;
	} item_t;

	typedef struct packed {
		logic [STAMP_WIDTH-1:0]  first;
		logic [STAMP_WIDTH-1:0]  last;
		logic [LENGTH_WIDTH-1:0] len;
		logic [LENGTH_WIDTH-1:0] intra;
		logic [LENGTH_WIDTH-1:0] fwd;
		logic [LENGTH_WIDTH-1:0] bidir;
		logic [BYTES_WIDTH-1:0]  bytes;
	} group_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0]  frames_closed;
		logic [LENGTH_WIDTH-1:0] longest;
		logic [LENGTH_WIDTH-1:0] shortest;
		logic [BYTES_WIDTH-1:0]  bytes;
		logic [LENGTH_WIDTH-1:0] bidir;
		logic [LENGTH_WIDTH-1:0] fwd;
		logic [LENGTH_WIDTH-1:0] intra;
		logic [LENGTH_WIDTH-1:0] len;
		logic [STAMP_WIDTH-1:0]  last;
		logic [STAMP_WIDTH-1:0]  first;
		logic [COUNT_WIDTH-1:0]  number;
	} result_t;

	function automatic logic [LENGTH_WIDTH-1:0] len_inc(input logic [LENGTH_WIDTH-1:0] v);
		logic [LENGTH_WIDTH:0] s;
		s = {1'b0, v} + {{LENGTH_WIDTH{1'b0}}, 1'b1};
		return s[LENGTH_WIDTH] ? {LENGTH_WIDTH{1'b1}} : s[LENGTH_WIDTH-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] v);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, v} + {{COUNT_WIDTH{1'b0}}, 1'b1};
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [BYTES_WIDTH-1:0] bytes_add(input logic [BYTES_WIDTH-1:0] v,
		input logic [FSIZE_WIDTH-1:0] a);
		logic [BYTES_WIDTH:0] s;
		s = {1'b0, v} + (BYTES_WIDTH+1)'(a);
		return s[BYTES_WIDTH] ? {BYTES_WIDTH{1'b1}} : s[BYTES_WIDTH-1:0];
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] count_add(input logic [COUNT_WIDTH-1:0] v,
		input logic [LENGTH_WIDTH-1:0] a);
		logic [COUNT_WIDTH:0] s;
		s = {1'b0, v} + (COUNT_WIDTH+1)'(a);
		return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
	endfunction

endpackage

@@ hw/rtl/gbs_front.sv @@
module gbs_front import gbs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_DATA_WIDTH-1:0] s_axis_tdata,
	input  logic [IN_USER_WIDTH-1:0] s_axis_tuser,
	input  logic                     s_axis_tlast,
	input  logic                     q_full,
	output logic                     q_push,
	output item_t                    q_item
);

	logic open_q;
	logic accept;
	logic boundary;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_push        = accept;

	assign boundary = open_q && (frame_type_t'(s_axis_tuser[TYPE_WIDTH-1:0]) == FT_INTRA)
		&& s_axis_tuser[TYPE_WIDTH];

	always_comb begin
		q_item.ftype      = frame_type_t'(s_axis_tuser[TYPE_WIDTH-1:0]);
		q_item.stream_end = s_axis_tlast;
		q_item.stamp      = s_axis_tdata[STAMP_WIDTH-1:0];
		q_item.fbytes     = s_axis_tdata[STAMP_WIDTH +: FSIZE_WIDTH];
		if (!open_q) begin
			q_item.kind = KIND_OPEN;
		end else if (boundary) begin
			q_item.kind = KIND_SPLIT;
		end else begin
			q_item.kind = KIND_JOIN;
		end
	end

	// A group stays open from any frame until the end of the stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (accept) begin
			open_q <= !s_axis_tlast;
		end
	end

endmodule

@@ hw/rtl/gbs_queue.sv @@
module gbs_queue import gbs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head
);

	localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

	item_t                entry_q [QUEUE_DEPTH];
	logic [PTR_WIDTH-1:0] wr_ptr_q;
	logic [PTR_WIDTH-1:0] rd_ptr_q;
	logic [CNT_WIDTH-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = (count_q == CNT_WIDTH'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_WIDTH-1:0] ptr_next(input logic [PTR_WIDTH-1:0] p);
		return (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

@@ hw/rtl/gbs_back.sv @@
module gbs_back import gbs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  item_t                     q_head,
	output logic                      q_pop,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata,
	output logic                      m_axis_tlast
);

	group_t                  grp_q;
	logic [COUNT_WIDTH-1:0]  number_q;
	logic [LENGTH_WIDTH-1:0] min_q;
	logic [LENGTH_WIDTH-1:0] max_q;
	logic [COUNT_WIDTH-1:0]  total_q;
	logic                    phase_q;
	logic                    out_valid_q;
	result_t                 out_q;
	logic                    out_final_q;

	group_t                  base;
	group_t                  nxt;
	group_t                  src;
	result_t                 res;
	logic                    split_first;
	logic                    final_res;
	logic                    needs_out;
	logic                    out_free;
	logic                    fire;
	logic                    emit;
	logic [LENGTH_WIDTH-1:0] min_n;
	logic [LENGTH_WIDTH-1:0] max_n;
	logic [COUNT_WIDTH-1:0]  total_n;

	always_comb begin
		base = (q_head.kind == KIND_JOIN) ? grp_q : '0;
		nxt.first = (q_head.kind == KIND_JOIN) ? grp_q.first : q_head.stamp;
		nxt.last  = q_head.stamp;
		nxt.len   = len_inc(base.len);
		nxt.intra = (q_head.ftype == FT_INTRA)   ? len_inc(base.intra) : base.intra;
		nxt.fwd   = (q_head.ftype == FT_FORWARD) ? len_inc(base.fwd)   : base.fwd;
		nxt.bidir = (q_head.ftype == FT_BIDIR)   ? len_inc(base.bidir) : base.bidir;
		nxt.bytes = bytes_add(base.bytes, q_head.fbytes);
	end

	// A split closes the stored group; a stream end flushes the group with this frame in it
	assign split_first = (q_head.kind == KIND_SPLIT) && !phase_q;
	assign src         = (split_first || phase_q) ? grp_q : nxt;
	assign final_res   = !split_first;
	assign needs_out   = phase_q || split_first || q_head.stream_end;
	assign out_free    = !out_valid_q || m_axis_tready;
	assign fire        = q_valid && (!needs_out || out_free);
	assign emit        = fire && needs_out;
	assign q_pop       = fire && !(split_first && q_head.stream_end);

	assign min_n   = (src.len < min_q) ? src.len : min_q;
	assign max_n   = (src.len > max_q) ? src.len : max_q;
	assign total_n = count_add(total_q, src.len);

	always_comb begin
		res.number        = number_q;
		res.first         = src.first;
		res.last          = src.last;
		res.len           = src.len;
		res.intra         = src.intra;
		res.fwd           = src.fwd;
		res.bidir         = src.bidir;
		res.bytes         = src.bytes;
		res.shortest      = min_n;
		res.longest       = max_n;
		res.frames_closed = total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q       <= '0;
			number_q    <= '0;
			min_q       <= '1;
			max_q       <= '0;
			total_q     <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				if (emit && final_res) begin
					// Stream over: back to a fresh stream
					grp_q    <= '0;
					number_q <= '0;
					min_q    <= '1;
					max_q    <= '0;
					total_q  <= '0;
					phase_q  <= 1'b0;
				end else if (emit) begin
					grp_q    <= nxt;
					number_q <= count_inc(number_q);
					min_q    <= min_n;
					max_q    <= max_n;
					total_q  <= total_n;
					phase_q  <= q_head.stream_end;
				end else begin
					grp_q <= nxt;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q       <= res;
			out_final_q <= final_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_WIDTH'(out_q);
	assign m_axis_tlast  = out_final_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (q_valid && q_head.kind == KIND_SPLIT && q_head.stream_end))
		else $error("second flush pending without a split at stream end");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.len != '0 && out_q.shortest <= out_q.longest))
		else $error("result with empty group or inverted length range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && final_res) |=> (grp_q.len == '0 && number_q == '0 && !phase_q))
		else $error("state not cleared after stream flush");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_head.kind == KIND_JOIN && !phase_q) |-> (grp_q.len != '0))
		else $error("frame joins a group that is not open");

endmodule

@@ hw/rtl/gop_boundary_statistics_core.sv @@
// Group-of-pictures statistics over a stream of frame descriptors.
// Slave channel s_axis takes one frame descriptor per transaction; tlast marks the
// last frame of a stream. Master channel m_axis gives one transaction per closed
// group, with tlast set on the group flushed at the end of a stream.
// A key I-frame closes the open group and opens the next one; any other last frame of a
// stream joins the open group, which is then flushed, and all statistics return to
// their reset values for the next stream.
// Throughput: one frame per cycle while m_axis takes results. A frame that is both a
// key I-frame and the end of a stream gives two results and leaves the queue only with
// the second. An accepted frame is written into the two-entry queue; the statistics
// unit reads it at the queue head and loads its result into the output register that
// drives m_axis. The second result of a key I-frame at stream end comes after the first.
// Reset clears the open group, group index, totals and the queue; the shortest
// length starts at all ones. When m_axis stalls, the output register holds its
// transaction, the statistics unit stops at the next frame that gives a result,
// and s_axis tready drops once the queue is full. Frames that give no result
// still drain while the output waits.
module gop_boundary_statistics_core import gbs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,  // timestamp, frame_bytes
	input  logic [IN_USER_WIDTH-1:0]  s_axis_tuser,  // frame_type, key_frame
	input  logic                      s_axis_tlast,  // stream_end
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// group_number, first_stamp, last_stamp, group_length, intra_count, forward_count,
	// bidir_count, group_bytes, shortest_length, longest_length, frames_closed
	output logic [OUT_DATA_WIDTH-1:0] m_axis_tdata,
	output logic                      m_axis_tlast   // final_group
);

	logic  q_full;
	logic  q_push;
	item_t q_item;
	logic  q_pop;
	logic  q_valid;
	item_t q_head;

	gbs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	gbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	gbs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
